// File: src/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared widths, character codes and handoff types for the signed binary to
// decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int WORD_W = 32;
  localparam int DIGITS = 10;
  localparam int BCD_W  = 4 * DIGITS;
  localparam int CHAR_W = 8;
  localparam int CNT_W  = $clog2(WORD_W);
  localparam int REM_W  = $clog2(DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic             neg;
  } bcd_xfer_t;

  typedef struct packed {
    logic valid;
  } xfer_ctl_t;

endpackage

// File: src/sbda_if.sv
// ----------------------------------------------------------------------------
// sbda_in_if / sbda_out_if
// Valid/ready channels for the integer input and the character output.
// ----------------------------------------------------------------------------
interface sbda_in_if
  import sbda_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sbda_out_if
  import sbda_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

// File: src/sbda_dabble.sv
// ----------------------------------------------------------------------------
// sbda_dabble
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit per
// cycle into a ten-digit BCD shift register.
// ----------------------------------------------------------------------------
module sbda_dabble
  import sbda_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  sbda_in_if.sink       in_if,
  output xfer_ctl_t     xo_ctl,
  input  logic          xo_ready,
  output bcd_xfer_t     xo_data
);

  typedef enum logic [2:0] {
    DB_IDLE = 3'b001,
    DB_CONV = 3'b010,
    DB_DONE = 3'b100
  } db_state_t;

  db_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [WORD_W-1:0]  mag_r, mag_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic               neg_r, neg_nxt;
  logic [BCD_W-1:0]   adj;
  logic [WORD_W-1:0]  raw;

  assign raw         = in_if.value;
  assign in_if.ready = (state_r == DB_IDLE);

  assign xo_ctl.valid = (state_r == DB_DONE);
  assign xo_data.bcd  = bcd_r;
  assign xo_data.neg  = neg_r;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                 : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    case (state_r)
      DB_IDLE: begin
        if (in_if.valid) begin
          neg_nxt   = raw[WORD_W-1];
          mag_nxt   = raw[WORD_W-1] ? (~raw + 1'b1) : raw;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = DB_CONV;
        end
      end
      DB_CONV: begin
        bcd_nxt = {adj[BCD_W-2:0], mag_r[WORD_W-1]};
        mag_nxt = {mag_r[WORD_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WORD_W - 1)) begin
          state_nxt = DB_DONE;
        end
      end
      DB_DONE: begin
        if (xo_ready) begin
          state_nxt = DB_IDLE;
        end
      end
      default: state_nxt = DB_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DB_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

endmodule

// File: src/sbda_emit.sv
// ----------------------------------------------------------------------------
// sbda_emit
// Character serializer: drops leading zeros one digit per cycle, then sends
// the sign and the digits through a registered output stage.
// ----------------------------------------------------------------------------
module sbda_emit
  import sbda_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  xfer_ctl_t     xi_ctl,
  output logic          xi_ready,
  input  bcd_xfer_t     xi_data,
  sbda_out_if.source    out_if
);

  typedef enum logic [3:0] {
    EM_IDLE  = 4'b0001,
    EM_SKIP  = 4'b0010,
    EM_SIGN  = 4'b0100,
    EM_DIGIT = 4'b1000
  } em_state_t;

  em_state_t          state_r, state_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic               neg_r, neg_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic               ov_r, ov_nxt;
  logic [CHAR_W-1:0]  ch_r, ch_nxt;
  logic               last_r, last_nxt;
  logic               can_push;
  logic [3:0]         top_dig;

  assign top_dig  = bcd_r[BCD_W-1 -: 4];
  assign can_push = !ov_r || out_if.ready;
  assign xi_ready = (state_r == EM_IDLE);

  assign out_if.valid      = ov_r;
  assign out_if.ascii_char = ch_r;
  assign out_if.last       = last_r;

  always_comb begin
    state_nxt = state_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    rem_nxt   = rem_r;
    ov_nxt    = ov_r && !out_if.ready;
    ch_nxt    = ch_r;
    last_nxt  = last_r;
    case (state_r)
      EM_IDLE: begin
        if (xi_ctl.valid) begin
          bcd_nxt   = xi_data.bcd;
          neg_nxt   = xi_data.neg;
          rem_nxt   = REM_W'(DIGITS);
          state_nxt = EM_SKIP;
        end
      end
      EM_SKIP: begin
        if (top_dig == 4'd0 && rem_r != REM_W'(1)) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          rem_nxt = rem_r - 1'b1;
        end else begin
          state_nxt = neg_r ? EM_SIGN : EM_DIGIT;
        end
      end
      EM_SIGN: begin
        if (can_push) begin
          ov_nxt    = 1'b1;
          ch_nxt    = ASCII_MINUS;
          last_nxt  = 1'b0;
          state_nxt = EM_DIGIT;
        end
      end
      EM_DIGIT: begin
        if (can_push) begin
          ov_nxt   = 1'b1;
          ch_nxt   = ASCII_ZERO + {4'd0, top_dig};
          last_nxt = (rem_r == REM_W'(1));
          bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
          rem_nxt  = rem_r - 1'b1;
          if (rem_r == REM_W'(1)) begin
            state_nxt = EM_IDLE;
          end
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    bcd_r  <= bcd_nxt;
    neg_r  <= neg_nxt;
    rem_r  <= rem_nxt;
    ch_r   <= ch_nxt;
    last_r <= last_nxt;
  end

endmodule

// File: src/signed_binary_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core
// Signed 32-bit integer to decimal ASCII text, most significant char first.
// ----------------------------------------------------------------------------
// Each transfer on in_if is one signed integer; out_if returns its decimal
// text one character per transfer, with a leading '-' for negative values,
// no leading zeros, a single '0' for zero, and last set on the final
// character. The magnitude is converted in a bit-serial shift-and-add-3
// unit, which hands the result off and returns to idle before it takes a
// new number; the hand-off waits until the character stage is idle. The
// character stage then drops the leading zeros one digit at a time (up to
// nine), starts output and sends one character per transfer (up to eleven)
// when the sink is ready. The converter accepts the next number as soon as
// it has handed off the previous one, so conversion overlaps with character
// output.
module signed_binary_to_decimal_ascii_core
  import sbda_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sbda_in_if.sink    in_if,
  sbda_out_if.source out_if
);

  xfer_ctl_t xfer_ctl;
  bcd_xfer_t xfer_data;
  logic      xfer_ready;

  sbda_dabble u_dabble (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .xo_ctl   (xfer_ctl),
    .xo_ready (xfer_ready),
    .xo_data  (xfer_data)
  );

  sbda_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .xi_ctl   (xfer_ctl),
    .xi_ready (xfer_ready),
    .xi_data  (xfer_data),
    .out_if   (out_if)
  );

endmodule

// File: src/sbda_checker.sv
// ----------------------------------------------------------------------------
// sbda_checker
// Port-level checks on the character output of the converter.
// ----------------------------------------------------------------------------
module sbda_checker
  import sbda_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char,
  input logic              out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("output changed while stalled");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_char == ASCII_MINUS ||
                  (out_char >= ASCII_ZERO && out_char <= ASCII_ZERO + 8'd9))
    else $error("character outside sign and digits");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char == ASCII_MINUS |-> !out_last)
    else $error("minus sign flagged as last");

  a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_char == ASCII_MINUS
      |=> out_valid && out_char != ASCII_MINUS)
    else $error("minus sign not followed by a digit");

endmodule

bind signed_binary_to_decimal_ascii_core sbda_checker u_sbda_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_char  (out_if.ascii_char),
  .out_last  (out_if.last)
);

// File: test/signed_binary_to_decimal_ascii_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core_test
// Self-checking bench for the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Each integer sent in is expanded here into its decimal text, and every
// character transfer out of the block is checked against that text in order.
// Directed values cover zero, both ends of the range and digit-count edges;
// the random part spreads magnitudes over every digit count and sign. Both
// channels idle at random, one phase runs with no idling, and one phase
// holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_core_test
  import sbda_pkg::*;
;

  localparam int RADIX      = 10;
  localparam int IDLE_PCT   = 13;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_LEN  = 80;

  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              last;
  } text_char_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sbda_in_if  in_ch ();
  sbda_out_if out_ch ();

  signed_binary_to_decimal_ascii_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #5 clk = ~clk;

  text_char_t expected_text[$];
  int         char_errors = 0;
  bit         no_idle     = 1'b0;
  int         hold_asked  = 0;
  int         hold_served = 0;

  function automatic void predict_text(input logic signed [WORD_W-1:0] v);
    logic [WORD_W-1:0] mag;
    logic [3:0]        dig [DIGITS];
    int                n;
    mag = v[WORD_W-1] ? (32'd0 - $unsigned(v)) : $unsigned(v);
    n   = 0;
    if (mag == 0) begin
      expected_text.push_back('{ascii_char: ASCII_ZERO, last: 1'b1});
      return;
    end
    while (mag != 0) begin
      dig[n] = 4'(mag % RADIX);
      mag    = mag / RADIX;
      n++;
    end
    if (v[WORD_W-1])
      expected_text.push_back('{ascii_char: ASCII_MINUS, last: 1'b0});
    for (int i = n - 1; i >= 0; i--)
      expected_text.push_back('{ascii_char: ASCII_ZERO + dig[i], last: (i == 0)});
  endfunction

  // valid stays high across back-to-back transfers; it drops only for a gap
  task automatic send_value(input logic signed [WORD_W-1:0] v);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_text(v);
  endtask

  function automatic logic signed [WORD_W-1:0] random_value();
    longint lim;
    int     k;
    logic signed [WORD_W-1:0] v;
    if ($urandom_range(3) == 0) return $urandom;
    k   = $urandom_range(1, DIGITS);
    lim = 1;
    for (int i = 0; i < k; i++) lim = lim * RADIX;
    lim = lim - 1;
    if (lim > 64'd2147483647) lim = 64'd2147483647;
    v = $urandom_range(32'(lim), 0);
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  // output side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_asked != hold_served) begin
        hold_served++;
        hold_left = HOLD_LEN - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_text.size() == 0) begin
        char_errors++;
        $display("%0t: unexpected char: expected none, actual char %0d last %0b",
                 $time, out_ch.ascii_char, out_ch.last);
      end else begin
        text_char_t exp_c;
        exp_c = expected_text.pop_front();
        if (out_ch.ascii_char !== exp_c.ascii_char || out_ch.last !== exp_c.last) begin
          char_errors++;
          $display("%0t: char mismatch: expected char %0d last %0b, actual char %0d last %0b",
                   $time, exp_c.ascii_char, exp_c.last, out_ch.ascii_char, out_ch.last);
        end
      end
    end
  end

  task automatic test_directed_values();
    logic signed [WORD_W-1:0] vals [$];
    vals = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000,
             32'sd9, 32'sd10, -32'sd9, -32'sd10, 32'sd99, 32'sd100,
             32'sd999999999, 32'sd1000000000, -32'sd1000000000,
             32'sh55555555, 32'shAAAAAAAA, 32'sd123456789, -32'sd987654321};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_random_flow(input int count);
    repeat (count) send_value(random_value());
  endtask

  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    repeat (count) send_value(random_value());
    no_idle = 1'b0;
  endtask

  task automatic test_output_hold_off(input int count);
    hold_asked++;
    repeat (count) send_value(random_value());
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_values();
    test_random_flow(82);
    test_back_to_back(40);
    test_output_hold_off(20);
    test_random_flow(60);

    in_ch.valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);

    if (char_errors == 0 && expected_text.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: signed_binary_to_decimal_ascii_core.f
src/sbda_pkg.sv
src/sbda_if.sv
src/sbda_dabble.sv
src/sbda_emit.sv
src/signed_binary_to_decimal_ascii_core.sv
src/sbda_checker.sv
test/signed_binary_to_decimal_ascii_core_test.sv
